>>> sv/mtlg_pkg.sv
// shared types and constants for the motion triggered launch gate
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package mtlg_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int Q_W           = 24;
	localparam int SCALE_W       = 17;
	localparam int TIME_W        = 32;
	localparam int PROD_W        = 2 * Q_W;
	localparam int ADDR_W        = 3;

	localparam logic [Q_W-1:0]     MAX_Q      = '1;
	localparam logic [SCALE_W-1:0] SCALE_ONE  = 17'h10000;
	localparam logic [9:0]         SCALE_STEP = 10'd655;

	// item actions
	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_MOTION = 2'd1,
		ACT_START  = 2'd2,
		ACT_STOP   = 2'd3
	} act_t;

	// configuration register indexes
	typedef enum logic [ADDR_W-1:0] {
		REG_FIRE_MODE     = 3'd0,
		REG_RESTORE_RATE  = 3'd1,
		REG_TRIGGER_LEVEL = 3'd2,
		REG_FIRE_COST     = 3'd3,
		REG_MIN_GAP       = 3'd4,
		REG_MOTION_DECAY  = 3'd5,
		REG_CHARGE_GAIN   = 3'd6,
		REG_MOTION_POWER  = 3'd7
	} reg_idx_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_START      = 4'd1,
		OP_STOP       = 4'd2,
		OP_TICK_BEGIN = 4'd3,
		OP_MOTION     = 4'd4,
		OP_MOTION_POW = 4'd5,
		OP_REFILL     = 4'd6,
		OP_FIRE_DECAY = 4'd7,
		OP_CHG_MUL    = 4'd8,
		OP_CHG_ADD    = 4'd9,
		OP_CHG_FIRE   = 4'd10
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_item;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		act_t action;
		logic running;
		logic stop_drop;
		logic fire_mode;
	} dp_status_t;

endpackage

>>> sv/mtlg_ifs.sv
// channel interfaces: item input, result output and configuration write
// depends on mtlg_pkg for field widths
interface mtlg_item_if import mtlg_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [1:0]     action;
	logic [Q_W-1:0] amount;

	modport source (output valid, action, amount, input ready);
	modport sink (input valid, action, amount, output ready);
endinterface

interface mtlg_result_if import mtlg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               fired;
	logic               is_active;
	logic [Q_W-1:0]     power_level;
	logic [Q_W-1:0]     motion_amount;
	logic [SCALE_W-1:0] ramp_scale;

	modport source (output valid, fired, is_active, power_level, motion_amount, ramp_scale,
		input ready);
	modport sink (input valid, fired, is_active, power_level, motion_amount, ramp_scale,
		output ready);
endinterface

interface mtlg_cfg_if import mtlg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] addr;
	logic [Q_W-1:0]    data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> sv/motion_triggered_launch_gate.sv
// top level of the motion triggered launch gate: controller plus datapath
// depends on mtlg_pkg, the channel interfaces in mtlg_ifs, mtlg_ctrl and mtlg_dp
//
// event trigger with a power credit. each item on src is a tick (amount = elapsed seconds),
// a motion report (amount = motion), a start or a stop, and each gives exactly one transfer
// on res holding the fire flag, the active flag, power, motion level and ramp scale after
// that item. values are unsigned q8.16 by default (FRAC_BITS fraction bits), sums saturate
// at all ones and differences stop at zero; the internal clock is q16.16 and wraps. in
// motion mode a tick refills power up to one and fires when motion has reached
// trigger_level, power exceeds fire_cost and min_gap has passed since the last fire; motion
// then clears and decays with time. in charge mode motion * dt * charge_gain becomes power
// and a fire clears power. a stop ramps the scale down and then the gate goes inactive.
// one item at a time: src is ready only when the sequencer is idle. start, stop and
// inactive ticks go straight to the result; motion adds a power step, a motion mode tick
// a refill and a fire and decay step, and a charge mode tick a multiply, add and fire step.
// the sequence follows the single shared 24x24 multiplier, which serves the refill, decay,
// charge and motion products one per cycle with its product registered. the result sits
// in an output register, so the next item is taken while a result still waits on res.
// cfg is always ready and must only be written while the gate is idle.

module motion_triggered_launch_gate import mtlg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mtlg_item_if.sink     src,
	mtlg_result_if.source res,
	mtlg_cfg_if.sink      cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// config writes are always accepted
	assign cfg.ready = 1'b1;

	// sequencer: one state per multiplier step
	mtlg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src.valid),
		.src_ready (src.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// registers, shared multiplier and result register
	mtlg_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.item_action   (src.action),
		.item_amount   (src.amount),
		.cfg_wr        (cfg.valid),
		.cfg_addr      (cfg.addr),
		.cfg_data      (cfg.data),
		.fired         (res.fired),
		.is_active     (res.is_active),
		.power_level   (res.power_level),
		.motion_amount (res.motion_amount),
		.ramp_scale    (res.ramp_scale)
	);

endmodule

>>> sv/mtlg_ctrl.sv
// sequencing state machine for the launch gate
// depends on mtlg_pkg; drives mtlg_dp through dp_cmd_t and reads dp_status_t
module mtlg_ctrl import mtlg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE       = 9'b000000001,
		S_EXEC       = 9'b000000010,
		S_REFILL     = 9'b000000100,
		S_FIRE_DECAY = 9'b000001000,
		S_CHG_MUL    = 9'b000010000,
		S_CHG_ADD    = 9'b000100000,
		S_CHG_FIRE   = 9'b001000000,
		S_MOT_POW    = 9'b010000000,
		S_DONE       = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;

	assign src_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.load_item = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (src_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (status.action)
					ACT_TICK: begin
						if (!status.running) begin
							state_d = S_DONE;
						end else begin
							cmd.op = OP_TICK_BEGIN;
							if (status.stop_drop) begin
								state_d = S_DONE;
							end else if (status.fire_mode) begin
								state_d = S_CHG_MUL;
							end else begin
								state_d = S_REFILL;
							end
						end
					end
					ACT_MOTION: begin
						cmd.op  = OP_MOTION;
						state_d = S_MOT_POW;
					end
					ACT_START: begin
						cmd.op  = OP_START;
						state_d = S_DONE;
					end
					ACT_STOP: begin
						cmd.op  = OP_STOP;
						state_d = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_REFILL: begin
				cmd.op  = OP_REFILL;
				state_d = S_FIRE_DECAY;
			end
			S_FIRE_DECAY: begin
				cmd.op  = OP_FIRE_DECAY;
				state_d = S_DONE;
			end
			S_CHG_MUL: begin
				cmd.op  = OP_CHG_MUL;
				state_d = S_CHG_ADD;
			end
			S_CHG_ADD: begin
				cmd.op  = OP_CHG_ADD;
				state_d = S_CHG_FIRE;
			end
			S_CHG_FIRE: begin
				cmd.op  = OP_CHG_FIRE;
				state_d = S_DONE;
			end
			S_MOT_POW: begin
				cmd.op  = OP_MOTION_POW;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!res_valid_q || res_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/mtlg_dp.sv
// datapath of the launch gate: config registers, trigger state, shared multiplier, result register
// depends on mtlg_pkg; sequenced by mtlg_ctrl
module mtlg_dp import mtlg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic [1:0]         item_action,
	input  logic [Q_W-1:0]     item_amount,
	input  logic               cfg_wr,
	input  logic [ADDR_W-1:0]  cfg_addr,
	input  logic [Q_W-1:0]     cfg_data,
	output logic               fired,
	output logic               is_active,
	output logic [Q_W-1:0]     power_level,
	output logic [Q_W-1:0]     motion_amount,
	output logic [SCALE_W-1:0] ramp_scale
);

	localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [Q_W-1:0] ONE_Q = (FRAC_BITS >= Q_W) ? MAX_Q : Q_W'(1 << FRAC_BITS);

	// configuration
	logic           fire_mode_q;
	logic [Q_W-1:0] restore_rate_q, trigger_level_q, fire_cost_q, min_gap_q;
	logic [Q_W-1:0] motion_decay_q, charge_gain_q, motion_power_q;

	// trigger state
	logic               running_q, stopping_q, fired_q;
	logic [SCALE_W-1:0] scale_q;
	logic [Q_W-1:0]     power_q, motion_q;
	logic [TIME_W-1:0]  clock_q, last_fire_q;

	// item and multiplier
	act_t              action_q;
	logic [Q_W-1:0]    amount_q;
	logic [PROD_W-1:0] prod_q;

	// result register
	logic               o_fired_q, o_active_q;
	logic [Q_W-1:0]     o_power_q, o_motion_q;
	logic [SCALE_W-1:0] o_scale_q;

	logic [TIME_W-1:0]  dq, gap_q16, since_fire;
	logic [PROD_W-1:0]  pshift;
	logic [Q_W-1:0]     psat;
	logic [PROD_W:0]    refill_sum;
	logic [Q_W:0]       psum, msum;
	logic [SCALE_W-1:0] scale_diff, scale_step;
	logic [26:0]        scale_prod;
	logic               gap_ok, fire_motion, fire_charge;
	logic [Q_W-1:0]     mul_a, mul_b;
	logic               mul_en;

	assign dq         = (TIME_W'(amount_q) >> SH_R) << SH_L;
	assign gap_q16    = (TIME_W'(min_gap_q) >> SH_R) << SH_L;
	assign since_fire = clock_q - last_fire_q;
	assign gap_ok     = (since_fire >= gap_q16);

	assign pshift     = prod_q >> FRAC_BITS;
	assign psat       = (|pshift[PROD_W-1:Q_W]) ? MAX_Q : pshift[Q_W-1:0];
	assign refill_sum = (PROD_W+1)'(power_q) + (PROD_W+1)'(pshift);
	assign psum       = (Q_W+1)'(power_q) + (Q_W+1)'(psat);
	assign msum       = (Q_W+1)'(motion_q) + (Q_W+1)'(amount_q);

	// ramp up toward one
	assign scale_diff = SCALE_ONE - scale_q;
	assign scale_prod = 27'(scale_diff) * 27'(SCALE_STEP);
	assign scale_step = SCALE_W'(scale_prod >> 16);

	assign fire_motion = (motion_q >= trigger_level_q) && (power_q > fire_cost_q) && gap_ok;
	assign fire_charge = (power_q >= trigger_level_q) && (power_q > fire_cost_q) && gap_ok;

	assign status.action    = action_q;
	assign status.running   = running_q;
	assign status.stop_drop = stopping_q && (dq >= TIME_W'(scale_q));
	assign status.fire_mode = fire_mode_q;

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = amount_q;
		mul_b  = amount_q;
		unique case (cmd.op)
			OP_TICK_BEGIN: mul_a = fire_mode_q ? motion_q : restore_rate_q;
			OP_MOTION:     mul_b = motion_power_q;
			OP_REFILL:     mul_a = motion_decay_q;
			OP_CHG_MUL: begin
				mul_a = psat;
				mul_b = charge_gain_q;
			end
			default:       mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.load_item) begin
			action_q <= act_t'(item_action);
			amount_q <= item_amount;
		end
		if (cmd.load_out) begin
			o_fired_q  <= fired_q;
			o_active_q <= running_q;
			o_power_q  <= power_q;
			o_motion_q <= motion_q;
			o_scale_q  <= scale_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_mode_q     <= 1'b0;
			restore_rate_q  <= 24'd13107;
			trigger_level_q <= 24'd32768;
			fire_cost_q     <= 24'd13107;
			min_gap_q       <= 24'd19661;
			motion_decay_q  <= 24'd65536;
			charge_gain_q   <= 24'd65536;
			motion_power_q  <= 24'd0;
			running_q       <= 1'b0;
			stopping_q      <= 1'b0;
			fired_q         <= 1'b0;
			scale_q         <= '0;
			power_q         <= ONE_Q;
			motion_q        <= '0;
			clock_q         <= '0;
			last_fire_q     <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx_t'(cfg_addr))
					REG_FIRE_MODE:     fire_mode_q     <= cfg_data[0];
					REG_RESTORE_RATE:  restore_rate_q  <= cfg_data;
					REG_TRIGGER_LEVEL: trigger_level_q <= cfg_data;
					REG_FIRE_COST:     fire_cost_q     <= cfg_data;
					REG_MIN_GAP:       min_gap_q       <= cfg_data;
					REG_MOTION_DECAY:  motion_decay_q  <= cfg_data;
					REG_CHARGE_GAIN:   charge_gain_q   <= cfg_data;
					REG_MOTION_POWER:  motion_power_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				fired_q <= 1'b0;
			end
			unique case (cmd.op) inside
				OP_START: begin
					stopping_q <= 1'b0;
					scale_q    <= '0;
					running_q  <= 1'b1;
					motion_q   <= '0;
					power_q    <= fire_mode_q ? '0 : ONE_Q;
				end
				OP_STOP: stopping_q <= 1'b1;
				OP_TICK_BEGIN: begin
					clock_q <= clock_q + dq;
					if (stopping_q) begin
						if (dq >= TIME_W'(scale_q)) begin
							scale_q   <= '0;
							running_q <= 1'b0;
						end else begin
							scale_q <= scale_q - SCALE_W'(dq);
						end
					end else begin
						scale_q <= scale_q + scale_step;
					end
				end
				OP_MOTION: motion_q <= msum[Q_W] ? MAX_Q : msum[Q_W-1:0];
				OP_MOTION_POW, OP_CHG_ADD: power_q <= psum[Q_W] ? MAX_Q : psum[Q_W-1:0];
				OP_REFILL: begin
					power_q <= (refill_sum > (PROD_W+1)'(ONE_Q)) ? ONE_Q : refill_sum[Q_W-1:0];
				end
				OP_FIRE_DECAY: begin
					if (fire_motion) begin
						power_q     <= power_q - fire_cost_q;
						last_fire_q <= clock_q;
						fired_q     <= 1'b1;
						motion_q    <= '0;
						if (restore_rate_q == '0) begin
							stopping_q <= 1'b1;
						end
					end else if (pshift >= PROD_W'(motion_q)) begin
						motion_q <= '0;
					end else begin
						motion_q <= motion_q - pshift[Q_W-1:0];
					end
				end
				OP_CHG_MUL: motion_q <= '0;
				OP_CHG_FIRE: begin
					if (fire_charge) begin
						power_q     <= '0;
						last_fire_q <= clock_q;
						fired_q     <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign fired         = o_fired_q;
	assign is_active     = o_active_q;
	assign power_level   = o_power_q;
	assign motion_amount = o_motion_q;
	assign ramp_scale    = o_scale_q;

endmodule
